// File: rtl/pr_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the partition rank block.
// Used by pr_table, pr_walk and partition_rank; depends on nothing.
package pr_pkg;

    localparam int MAX_N       = 256;
    localparam int STORE_DEPTH = 256;
    localparam int PART_W      = 9;
    localparam int TOTAL_W     = 10;
    localparam int CNT_W       = 9;
    localparam int RANK_W      = 56;
    localparam int IDX_W       = $clog2(MAX_N);
    localparam int TBL_AW      = 2 * IDX_W;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int TOTAL_MAX   = (1 << TOTAL_W) - 1;

    typedef logic [RANK_W-1:0] rank_t;

    typedef struct packed {
        logic              rd;
        logic [PART_W-1:0] row;
        logic [PART_W-1:0] col;
    } tbl_req_t;

    typedef struct packed {
        logic  vld;
        rank_t rank;
        logic  too_large;
    } res_t;

endpackage

// File: rtl/pr_table.sv
`timescale 1ns / 1ps
// Count table memory: after reset it fills itself row by row with additions only,
// then serves lookup requests from the walk. Depends on pr_pkg.
module pr_table (
    input  logic             clk,
    input  logic             rst_n,
    input  pr_pkg::tbl_req_t req,
    output pr_pkg::rank_t    rdata,
    output logic             ready
);

    pr_pkg::rank_t                     table_mem [0:(1 << pr_pkg::TBL_AW)-1];
    pr_pkg::rank_t                     rdata_reg;

    logic [pr_pkg::PART_W-1:0]         row_reg, row_next;
    logic [pr_pkg::PART_W-1:0]         col_reg, col_next;
    logic                              run_reg, run_next;
    logic                              ready_reg, ready_next;

    logic                              st_vld_reg, st_vld_next;
    logic                              st_first_reg;
    logic                              st_last_reg;
    logic                              st_one_reg;
    logic                              st_zero_reg;
    logic [pr_pkg::TBL_AW-1:0]         st_waddr_reg;
    pr_pkg::rank_t                     prev_reg;

    logic [pr_pkg::PART_W-1:0]         src;
    logic [pr_pkg::PART_W-1:0]         src_m1;
    logic [pr_pkg::PART_W-1:0]         row_m1;
    logic [pr_pkg::PART_W-1:0]         col_m1;
    logic [pr_pkg::PART_W-1:0]         req_row_m1;
    logic [pr_pkg::PART_W-1:0]         req_col_m1;
    logic                              fill_one;
    logic                              fill_zero;
    logic                              fill_first;
    logic                              fill_last;
    logic [pr_pkg::TBL_AW-1:0]         fill_raddr;
    logic [pr_pkg::TBL_AW-1:0]         fill_waddr;
    logic                              mem_re;
    logic [pr_pkg::TBL_AW-1:0]         mem_raddr;
    pr_pkg::rank_t                     st_val;
    pr_pkg::rank_t                     st_sum;

    always_comb
    begin
        src        = row_reg - col_reg;
        src_m1     = src - 9'd1;
        row_m1     = row_reg - 9'd1;
        col_m1     = col_reg - 9'd1;
        fill_one   = (src == '0);
        fill_zero  = !fill_one && (col_reg > src);
        fill_first = (col_reg == row_reg);
        fill_last  = (row_reg == pr_pkg::PART_W'(pr_pkg::MAX_N)) && (col_reg == 9'd1);
        fill_raddr = {src_m1[pr_pkg::IDX_W-1:0], col_m1[pr_pkg::IDX_W-1:0]};
        fill_waddr = {row_m1[pr_pkg::IDX_W-1:0], col_m1[pr_pkg::IDX_W-1:0]};
        req_row_m1 = req.row - 9'd1;
        req_col_m1 = req.col - 9'd1;

        if (run_reg)
        begin
            mem_re    = 1'b1;
            mem_raddr = fill_raddr;
        end
        else
        begin
            mem_re    = req.rd;
            mem_raddr = {req_row_m1[pr_pkg::IDX_W-1:0], req_col_m1[pr_pkg::IDX_W-1:0]};
        end

        row_next = row_reg;
        col_next = col_reg;
        run_next = run_reg;
        if (run_reg)
        begin
            if (col_reg == 9'd1)
            begin
                row_next = row_reg + 9'd1;
                col_next = row_reg + 9'd1;
            end
            else
            begin
                col_next = col_reg - 9'd1;
            end
            if (fill_last)
            begin
                run_next = 1'b0;
            end
        end
        st_vld_next = run_reg;

        if (st_one_reg)
        begin
            st_val = pr_pkg::rank_t'(1);
        end
        else if (st_zero_reg)
        begin
            st_val = '0;
        end
        else
        begin
            st_val = rdata_reg;
        end
        st_sum     = (st_first_reg ? '0 : prev_reg) + st_val;
        ready_next = ready_reg || (st_vld_reg && st_last_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg    <= 9'd1;
            col_reg    <= 9'd1;
            run_reg    <= 1'b1;
            st_vld_reg <= 1'b0;
            ready_reg  <= 1'b0;
        end
        else
        begin
            row_reg    <= row_next;
            col_reg    <= col_next;
            run_reg    <= run_next;
            st_vld_reg <= st_vld_next;
            ready_reg  <= ready_next;
        end
    end

    always_ff @(posedge clk)
    begin
        st_first_reg <= fill_first;
        st_last_reg  <= fill_last;
        st_one_reg   <= fill_one;
        st_zero_reg  <= fill_zero;
        st_waddr_reg <= fill_waddr;
        if (st_vld_reg)
        begin
            prev_reg <= st_sum;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_vld_reg)
        begin
            table_mem[st_waddr_reg] <= st_sum;
        end
        if (mem_re)
        begin
            rdata_reg <= table_mem[mem_raddr];
        end
    end

    assign rdata = rdata_reg;
    assign ready = ready_reg;

endmodule

// File: rtl/pr_walk.sv
`timescale 1ns / 1ps
// Part store and ranking walk: buffers the parts of one partition, then steps
// through them and accumulates count table entries. Depends on pr_pkg.
module pr_walk (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      tbl_ready,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [pr_pkg::PART_W-1:0] part_value,
    input  logic                      last_part,
    output pr_pkg::tbl_req_t          tbl_req,
    input  pr_pkg::rank_t             tbl_rdata,
    output pr_pkg::res_t              res,
    input  logic                      res_take
);

    localparam logic [2:0] W_IDLE  = 3'd0;
    localparam logic [2:0] W_PREAD = 3'd1;
    localparam logic [2:0] W_PLOAD = 3'd2;
    localparam logic [2:0] W_JLOOP = 3'd3;
    localparam logic [2:0] W_DONE  = 3'd4;

    logic [pr_pkg::PART_W-1:0]  store_mem [0:pr_pkg::STORE_DEPTH-1];
    logic [pr_pkg::PART_W-1:0]  store_rdata_reg;

    logic [2:0]                 state_reg, state_next;
    logic [pr_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [pr_pkg::TOTAL_W-1:0] total_reg, total_next;
    logic [pr_pkg::CNT_W-1:0]   k_reg, k_next;
    logic [pr_pkg::PART_W-1:0]  lower_reg, lower_next;
    logic [pr_pkg::PART_W-1:0]  rem_reg, rem_next;
    logic [pr_pkg::PART_W-1:0]  p_reg, p_next;
    logic [pr_pkg::PART_W-1:0]  j_reg, j_next;
    pr_pkg::rank_t              acc_reg, acc_next;
    logic                       too_reg, too_next;
    logic                       lk_vld_reg, lk_vld_next;
    logic                       lk_one_reg, lk_one_next;
    logic                       lk_zero_reg, lk_zero_next;

    logic                       accept;
    logic                       nz;
    logic [pr_pkg::TOTAL_W:0]   tot_sum;
    logic [pr_pkg::TOTAL_W-1:0] tot_new;
    logic [pr_pkg::CNT_W-1:0]   cnt_new;
    logic                       too;
    logic                       store_we;
    logic                       store_re;
    logic [pr_pkg::PART_W-1:0]  src;
    logic [pr_pkg::CNT_W-1:0]   k_inc;
    pr_pkg::rank_t              lk_val;

    always_comb
    begin
        in_stall = !(tbl_ready && (state_reg == W_IDLE));
        accept   = in_valid && !in_stall;
        nz       = (part_value != '0);
        tot_sum  = {1'b0, total_reg} + {2'b00, part_value};
        if (tot_sum > (pr_pkg::TOTAL_W+1)'(pr_pkg::TOTAL_MAX))
        begin
            tot_new = pr_pkg::TOTAL_W'(pr_pkg::TOTAL_MAX);
        end
        else
        begin
            tot_new = tot_sum[pr_pkg::TOTAL_W-1:0];
        end
        if (nz && (cnt_reg <= pr_pkg::CNT_W'(pr_pkg::STORE_DEPTH)))
        begin
            cnt_new = cnt_reg + 9'd1;
        end
        else
        begin
            cnt_new = cnt_reg;
        end
        too      = (tot_new > pr_pkg::TOTAL_W'(pr_pkg::MAX_N))
                   || (cnt_new > pr_pkg::CNT_W'(pr_pkg::STORE_DEPTH));
        store_we = accept && nz && (cnt_reg < pr_pkg::CNT_W'(pr_pkg::STORE_DEPTH));
        store_re = (state_reg == W_PREAD);

        src          = rem_reg - j_reg;
        lk_one_next  = (src == '0);
        lk_zero_next = !lk_one_next && (j_reg > src);
        k_inc        = k_reg + 9'd1;

        if (lk_one_reg)
        begin
            lk_val = pr_pkg::rank_t'(1);
        end
        else if (lk_zero_reg)
        begin
            lk_val = '0;
        end
        else
        begin
            lk_val = tbl_rdata;
        end

        state_next  = state_reg;
        cnt_next    = cnt_reg;
        total_next  = total_reg;
        k_next      = k_reg;
        lower_next  = lower_reg;
        rem_next    = rem_reg;
        p_next      = p_reg;
        j_next      = j_reg;
        too_next    = too_reg;
        lk_vld_next = 1'b0;
        acc_next    = lk_vld_reg ? (acc_reg + lk_val) : acc_reg;
        tbl_req     = '{rd: 1'b0, row: src, col: j_reg};

        case (state_reg)
            W_IDLE:
            begin
                if (accept)
                begin
                    cnt_next   = cnt_new;
                    total_next = tot_new;
                    if (last_part)
                    begin
                        too_next   = too;
                        acc_next   = '0;
                        k_next     = '0;
                        lower_next = 9'd1;
                        rem_next   = tot_new[pr_pkg::PART_W-1:0];
                        if (too || (cnt_new == '0))
                        begin
                            state_next = W_DONE;
                        end
                        else
                        begin
                            state_next = W_PREAD;
                        end
                    end
                end
            end
            W_PREAD:
            begin
                state_next = W_PLOAD;
            end
            W_PLOAD:
            begin
                p_next     = store_rdata_reg;
                j_next     = lower_reg;
                state_next = W_JLOOP;
            end
            W_JLOOP:
            begin
                if (j_reg < p_reg)
                begin
                    tbl_req.rd  = 1'b1;
                    lk_vld_next = 1'b1;
                    j_next      = j_reg + 9'd1;
                end
                else
                begin
                    lower_next = p_reg;
                    rem_next   = (p_reg <= rem_reg) ? (rem_reg - p_reg) : '0;
                    k_next     = k_inc;
                    state_next = (k_inc == cnt_reg) ? W_DONE : W_PREAD;
                end
            end
            W_DONE:
            begin
                if (res_take)
                begin
                    cnt_next   = '0;
                    total_next = '0;
                    state_next = W_IDLE;
                end
            end
            default:
            begin
                state_next = W_IDLE;
            end
        endcase

        res.vld       = (state_reg == W_DONE);
        res.rank      = too_reg ? '0 : acc_reg;
        res.too_large = too_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= W_IDLE;
            cnt_reg    <= '0;
            total_reg  <= '0;
            lk_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            total_reg  <= total_next;
            lk_vld_reg <= lk_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg       <= k_next;
        lower_reg   <= lower_next;
        rem_reg     <= rem_next;
        p_reg       <= p_next;
        j_reg       <= j_next;
        acc_reg     <= acc_next;
        too_reg     <= too_next;
        lk_one_reg  <= lk_one_next;
        lk_zero_reg <= lk_zero_next;
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_mem[cnt_reg[pr_pkg::STORE_AW-1:0]] <= part_value;
        end
        if (store_re)
        begin
            store_rdata_reg <= store_mem[k_reg[pr_pkg::STORE_AW-1:0]];
        end
    end

endmodule

// File: rtl/partition_rank.sv
`timescale 1ns / 1ps
// Lexicographic rank of an integer partition. Depends on pr_pkg, pr_table and pr_walk.
// After reset the count table fills itself one entry per cycle, and no request is taken
// until then. A part without the last flag leaves the walk idle. A last part, unless too
// large or empty, runs W_PREAD, W_PLOAD and W_JLOOP for each stored part, one lookup per
// W_JLOOP step; lookups stay below the largest part for non-decreasing parts and never
// exceed the total. Input stalls until the result has moved to the output register.
module partition_rank (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [pr_pkg::PART_W-1:0] part_value,
    input  logic                      last_part,
    output logic                      out_valid,
    input  logic                      out_stall,
    output pr_pkg::rank_t             rank,
    output logic                      too_large
);

    pr_pkg::tbl_req_t tbl_req;
    pr_pkg::rank_t    tbl_rdata;
    logic             tbl_ready;
    pr_pkg::res_t     res;
    logic             res_take;

    logic             out_valid_reg, out_valid_next;
    pr_pkg::rank_t    rank_reg;
    logic             too_large_reg;

    pr_table u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (tbl_req),
        .rdata (tbl_rdata),
        .ready (tbl_ready)
    );

    pr_walk u_walk (
        .clk        (clk),
        .rst_n      (rst_n),
        .tbl_ready  (tbl_ready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .part_value (part_value),
        .last_part  (last_part),
        .tbl_req    (tbl_req),
        .tbl_rdata  (tbl_rdata),
        .res        (res),
        .res_take   (res_take)
    );

    always_comb
    begin
        res_take = res.vld && (!out_valid_reg || !out_stall);
        if (res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            rank_reg      <= res.rank;
            too_large_reg <= res.too_large;
        end
    end

    assign out_valid = out_valid_reg;
    assign rank      = rank_reg;
    assign too_large = too_large_reg;

    // No request may enter before the count table is complete.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> tbl_ready)
        else $error("request accepted before the count table was filled");

    // An oversized partition always reports a rank of zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && too_large) |-> (rank == '0))
        else $error("nonzero rank reported with the overflow flag");

    // No result can exist while the table is still filling.
    assert property (@(posedge clk) disable iff (!rst_n)
        !tbl_ready |-> (!out_valid && !res.vld))
        else $error("result present before the count table was filled");

endmodule

// File: tb/sv/partition_rank_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for partition_rank: parts are queued, driven in bursts and
// ranked by a predictor built on its own count table. Depends on pr_pkg and partition_rank.
module partition_rank_test;

    localparam int ITEM_TARGET = 1750;
    localparam int LAST_FLAG   = 1 << 10;
    localparam int HOLD_CYCLES = 3000;
    localparam int TAIL_CYCLES = 2000;

    typedef struct {
        logic [pr_pkg::PART_W-1:0] value;
        logic                      last;
        bit                        drain;
    } part_req_t;

    typedef struct packed {
        pr_pkg::rank_t rank;
        logic          too_large;
    } rank_exp_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic [pr_pkg::PART_W-1:0] part_value = '0;
    logic                      last_part = 1'b0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    pr_pkg::rank_t             rank;
    logic                      too_large;

    part_req_t pending_q[$];
    rank_exp_t rank_q[$];
    int        draft[$];

    pr_pkg::rank_t             part_cnt [0:pr_pkg::MAX_N][0:pr_pkg::MAX_N+1];
    logic [pr_pkg::PART_W-1:0] held_parts [0:pr_pkg::STORE_DEPTH-1];
    int                        held_count = 0;
    int                        held_total = 0;

    int errors = 0;
    int results_seen = 0;
    int burst_left = 0;
    int gap_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int stall_mode = 0;
    int mode_left = 0;
    int stall_tick = 0;

    partition_rank u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .part_value (part_value),
        .last_part  (last_part),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .rank       (rank),
        .too_large  (too_large)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic pr_pkg::rank_t walk_lex_rank();
        pr_pkg::rank_t acc;
        int            lower;
        int            remaining;
        int            p;
        acc = '0;
        lower = 1;
        remaining = held_total;
        for (int k = 0; k < held_count && k < pr_pkg::STORE_DEPTH; k++)
        begin
            p = held_parts[k];
            for (int j = lower; j < p; j++)
            begin
                if (j <= remaining && (remaining - j) <= pr_pkg::MAX_N
                    && j <= pr_pkg::MAX_N + 1)
                    acc = acc + part_cnt[remaining - j][j];
            end
            lower = p;
            remaining = (p <= remaining) ? remaining - p : 0;
        end
        return acc;
    endfunction

    task automatic absorb_part(input logic [pr_pkg::PART_W-1:0] v, input logic last);
        rank_exp_t want;
        if (v != 0)
        begin
            if (held_count < pr_pkg::STORE_DEPTH)
                held_parts[held_count] = v;
            if (held_count <= pr_pkg::STORE_DEPTH)
                held_count++;
            held_total += v;
            if (held_total > pr_pkg::TOTAL_MAX)
                held_total = pr_pkg::TOTAL_MAX;
        end
        if (last)
        begin
            if (held_total > pr_pkg::MAX_N || held_count > pr_pkg::STORE_DEPTH)
            begin
                want.rank = '0;
                want.too_large = 1'b1;
            end
            else
            begin
                want.rank = walk_lex_rank();
                want.too_large = 1'b0;
            end
            rank_q.insert(rank_q.size(), want);
            held_count = 0;
            held_total = 0;
        end
    endtask

    task automatic queue_draft(input bit drain);
        part_req_t r;
        for (int k = 0; k < draft.size(); k++)
        begin
            r.value = pr_pkg::PART_W'(draft[k]);
            r.last = (k == draft.size() - 1);
            r.drain = drain && (k == 0);
            pending_q.insert(pending_q.size(), r);
        end
    endtask

    task automatic build_partition(input int total);
        int lower;
        int rem;
        int hi;
        int p;
        lower = 1;
        rem = total;
        draft = {};
        while (rem > 0)
        begin
            if ($urandom_range(0, 3) == 0)
                hi = rem;
            else
                hi = (lower + 4 < rem) ? lower + 4 : rem;
            p = $urandom_range(hi, lower);
            if (rem - p > 0 && rem - p < p)
                p = rem;
            draft.insert(draft.size(), p);
            lower = p;
            rem -= p;
        end
    endtask

    task automatic build_ones(input int count);
        draft = {};
        repeat (count) draft.insert(draft.size(), 1);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : driver
        part_req_t nxt;
        logic      taken;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            part_value <= '0;
            last_part <= 1'b0;
        end
        else
        begin
            taken = in_valid && !in_stall;
            if (taken)
                absorb_part(part_value, last_part);
            if (!in_valid || taken)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_q.size() == 0)
                    in_valid <= 1'b0;
                else if (pending_q[0].drain && (rank_q.size() != 0 || out_valid))
                    in_valid <= 1'b0;
                else
                begin
                    nxt = pending_q.pop_front();
                    part_value <= nxt.value;
                    last_part <= nxt.last;
                    in_valid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(32, 1);
                        if ($urandom_range(0, 3) == 0)
                            gap_left = 0;
                        else if ($urandom_range(0, 15) == 0)
                            gap_left = $urandom_range(60, 20);
                        else
                            gap_left = $urandom_range(6, 1);
                    end
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : long_hold
        if (!rst_n)
            hold_left <= 0;
        else if (!hold_done && results_seen >= 30)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk or negedge rst_n)
    begin : monitor
        rank_exp_t want;
        logic      stall_bit;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen <= results_seen + 1;
                if (rank_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, rank %0d too_large %0b",
                             $time, rank, too_large);
                end
                else
                begin
                    want = rank_q.pop_front();
                    if (rank !== want.rank)
                    begin
                        errors++;
                        $display("%0t: rank mismatch, expected %0d, actual %0d",
                                 $time, want.rank, rank);
                    end
                    if (too_large !== want.too_large)
                    begin
                        errors++;
                        $display("%0t: too_large mismatch, expected %0b, actual %0b",
                                 $time, want.too_large, too_large);
                    end
                end
            end
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(3, 0);
                mode_left = $urandom_range(500, 50);
            end
            else
                mode_left--;
            stall_tick++;
            case (stall_mode)
                0: stall_bit = 1'b0;
                1: stall_bit = ($urandom_range(0, 3) == 0);
                2: stall_bit = ($urandom_range(0, 3) != 0);
                default: stall_bit = (stall_tick % 3 == 0);
            endcase
            out_stall <= (hold_left != 0) || stall_bit;
        end
    end

    initial
    begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int directed [25] = '{
            1 + LAST_FLAG,
            256 + LAST_FLAG,
            0 + LAST_FLAG,
            1, 1, 2 + LAST_FLAG,
            2, 0, 3 + LAST_FLAG,
            3, 0 + LAST_FLAG,
            5, 3, 1 + LAST_FLAG,
            255, 1 + LAST_FLAG,
            128, 128 + LAST_FLAG,
            200, 100 + LAST_FLAG,
            511, 511, 511 + LAST_FLAG,
            256, 1 + LAST_FLAG
        };
        part_req_t r;
        int        n_part;
        int        kind;
        int        total;
        int        pos;
        int        sel;

        for (int i = 0; i <= pr_pkg::MAX_N; i++)
        begin
            part_cnt[i][pr_pkg::MAX_N + 1] = (i == 0) ? pr_pkg::rank_t'(1)
                                                      : pr_pkg::rank_t'(0);
            for (int m = pr_pkg::MAX_N; m >= 1; m--)
            begin
                if (i == 0)
                    part_cnt[i][m] = pr_pkg::rank_t'(1);
                else if (m > i)
                    part_cnt[i][m] = '0;
                else
                    part_cnt[i][m] = part_cnt[i][m + 1] + part_cnt[i - m][m];
            end
            part_cnt[i][0] = '0;
        end

        foreach (directed[k])
        begin
            r.value = pr_pkg::PART_W'(directed[k] & 511);
            r.last = (directed[k] & LAST_FLAG) != 0;
            r.drain = 1'b0;
            pending_q.insert(pending_q.size(), r);
        end

        n_part = 0;
        while (pending_q.size() < ITEM_TARGET)
        begin
            kind = $urandom_range(99, 0);
            if (n_part == 40)
                build_ones(256);
            else if (n_part == 120)
                build_ones(257);
            else if (kind < 65)
            begin
                sel = $urandom_range(99, 0);
                if (sel < 80)
                    total = $urandom_range(30, 1);
                else if (sel < 95)
                    total = $urandom_range(120, 31);
                else
                    total = $urandom_range(pr_pkg::MAX_N, 121);
                build_partition(total);
            end
            else if (kind < 75)
                build_partition($urandom_range(400, pr_pkg::MAX_N + 1));
            else if (kind < 85)
            begin
                build_partition($urandom_range(60, 2));
                draft.shuffle();
            end
            else if (kind < 95)
            begin
                draft = {};
                repeat ($urandom_range(5, 1))
                begin
                    if ($urandom_range(0, 3) == 0)
                        draft.insert(draft.size(), 0);
                    else
                        draft.insert(draft.size(), $urandom_range(511, 1));
                end
            end
            else
            begin
                build_partition($urandom_range(40, 1));
                repeat ($urandom_range(3, 1))
                begin
                    pos = $urandom_range(draft.size(), 0);
                    draft.insert(pos, 0);
                end
                if ($urandom_range(0, 1) == 0)
                    draft.insert(draft.size(), 0);
            end
            queue_draft(n_part == 0 || n_part == 70);
            n_part++;
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_q.size() != 0 || in_valid)
            @(posedge clk);
        while (rank_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: sim.f
rtl/pr_pkg.sv
rtl/pr_table.sv
rtl/pr_walk.sv
rtl/partition_rank.sv
tb/sv/partition_rank_test.sv
